// ----- hdl/tlb_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tlb_pkg
// Types, constants and helpers shared by the timed led blink controller.
// ----------------------------------------------------------------------------
package tlb_pkg;

    localparam int unsigned MAX_BLINK_MS_DEF    = 15000;
    localparam int unsigned SETTLE_DELAY_MS_DEF = 50;

    localparam logic signed [31:0] STEADY_THRESHOLD = 32'sd3600000;
    localparam logic signed [31:0] REQ_BLINK_FOREVER = -32'sd1;

    localparam logic [1:0] FREQ_LEVEL_RESET = 2'd1;

    localparam logic [1:0] FREQ_FAST = 2'd0;
    localparam logic [1:0] FREQ_SLOW = 2'd2;

    localparam logic [9:0] HALF_FAST_MS = 10'd250;
    localparam logic [9:0] HALF_MID_MS  = 10'd500;
    localparam logic [9:0] HALF_SLOW_MS = 10'd1000;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_BLINK
    } tlb_mode_t;

    typedef struct packed {
        logic              command;
        logic signed [31:0] request_ms;
    } tlb_in_item_t;

    typedef struct packed {
        logic        led_level;
        logic [13:0] remaining_ms;
    } tlb_out_item_t;

    function automatic logic [9:0] half_period(input logic [1:0] level);
        logic [9:0] hp;
        case (level)
            FREQ_FAST: hp = HALF_FAST_MS;
            FREQ_SLOW: hp = HALF_SLOW_MS;
            default:   hp = HALF_MID_MS;
        endcase
        return hp;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/tlb_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tlb_core
// Blink, settle and timeout state, updated once per accepted item.
// ----------------------------------------------------------------------------
module tlb_core
    import tlb_pkg::*;
#(
    parameter int unsigned MAX_BLINK_MS    = MAX_BLINK_MS_DEF,
    parameter int unsigned SETTLE_DELAY_MS = SETTLE_DELAY_MS_DEF
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          item_accept,
    input  wire tlb_in_item_t  item,
    input  wire logic          cfg_write,
    input  wire logic [1:0]    cfg_data,
    output tlb_out_item_t      result
);

    localparam logic [13:0] MAX_MS    = 14'(MAX_BLINK_MS);
    localparam logic [5:0]  SETTLE_MS = 6'(SETTLE_DELAY_MS);
    localparam logic signed [31:0] MAX_MS_S = $signed({18'd0, MAX_MS});

    logic [1:0]  freq_level_reg;
    tlb_mode_t   mode_reg, mode_next;
    logic [9:0]  phase_reg, phase_next;
    logic        led_reg, led_next;
    logic [13:0] timeout_reg, timeout_next;
    logic [5:0]  settle_reg, settle_next;
    logic        target_reg, target_next;

    logic [10:0] phase_inc;

    always_comb
    begin
        mode_next    = mode_reg;
        phase_next   = phase_reg;
        led_next     = led_reg;
        timeout_next = timeout_reg;
        settle_next  = settle_reg;
        target_next  = target_reg;
        phase_inc    = {1'b0, phase_reg} + 11'd1;

        if (item.command == CMD_WRITE)
        begin
            timeout_next = '0;
            if (item.request_ms == 32'sd0 || item.request_ms > STEADY_THRESHOLD)
            begin
                // off or steady on, applied after the settle delay
                mode_next   = MODE_IDLE;
                phase_next  = '0;
                target_next = (item.request_ms != 32'sd0);
                settle_next = SETTLE_MS;
                if (SETTLE_MS == 6'd0)
                begin
                    led_next = target_next;
                end
            end
            else if (item.request_ms == REQ_BLINK_FOREVER || item.request_ms > 32'sd0)
            begin
                mode_next   = MODE_BLINK;
                phase_next  = '0;
                settle_next = '0;
                led_next    = 1'b1;
                if (item.request_ms > 32'sd0)
                begin
                    timeout_next = (item.request_ms > MAX_MS_S) ? MAX_MS
                                                               : item.request_ms[13:0];
                end
            end
        end
        else
        begin
            if (mode_reg == MODE_BLINK)
            begin
                if (phase_inc >= {1'b0, half_period(freq_level_reg)})
                begin
                    led_next   = ~led_reg;
                    phase_next = '0;
                end
                else
                begin
                    phase_next = phase_inc[9:0];
                end
            end
            else if (settle_reg != 6'd0)
            begin
                settle_next = settle_reg - 6'd1;
                if (settle_next == 6'd0)
                begin
                    led_next = target_reg;
                end
            end

            if (timeout_reg != 14'd0)
            begin
                timeout_next = timeout_reg - 14'd1;
                if (timeout_next == 14'd0)
                begin
                    // expiry stops the blink and starts an off settle
                    mode_next   = MODE_IDLE;
                    phase_next  = '0;
                    target_next = 1'b0;
                    settle_next = SETTLE_MS;
                    if (SETTLE_MS == 6'd0)
                    begin
                        led_next = 1'b0;
                    end
                end
            end
        end
    end

    always_comb
    begin
        result.led_level    = led_next;
        result.remaining_ms = timeout_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_level_reg <= FREQ_LEVEL_RESET;
            mode_reg       <= MODE_IDLE;
            phase_reg      <= '0;
            led_reg        <= 1'b0;
            timeout_reg    <= '0;
            settle_reg     <= '0;
            target_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                freq_level_reg <= cfg_data;
            end
            if (item_accept)
            begin
                mode_reg    <= mode_next;
                phase_reg   <= phase_next;
                led_reg     <= led_next;
                timeout_reg <= timeout_next;
                settle_reg  <= settle_next;
                target_reg  <= target_next;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_timeout_only_blinking: assert property (@(posedge clk) disable iff (!rst_n)
        (timeout_reg != 14'd0) |-> (mode_reg == MODE_BLINK))
        else $error("timeout running outside blink");

    a_settle_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (settle_reg != 6'd0) |-> (mode_reg == MODE_IDLE))
        else $error("settle pending while blinking");

    a_phase_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg < HALF_SLOW_MS)
        else $error("phase count beyond longest half period");
`endif

endmodule
`default_nettype wire

// ----- hdl/tlb_out_buf.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tlb_out_buf
// Output register plus a skid stage that holds one more result during stalls.
// ----------------------------------------------------------------------------
module tlb_out_buf
    import tlb_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire tlb_out_item_t push_data,
    output logic               full,
    output logic               out_valid,
    input  wire logic          out_stall,
    output tlb_out_item_t      out_item
);

    logic          main_valid_reg, main_valid_next;
    logic          skid_valid_reg, skid_valid_next;
    tlb_out_item_t main_data_reg, main_data_next;
    tlb_out_item_t skid_data_reg, skid_data_next;
    logic          pop;

    assign pop = main_valid_reg && !out_stall;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                main_data_next  = skid_data_reg;
                skid_valid_next = push;
                skid_data_next  = push_data;
            end
            else
            begin
                main_valid_next = push;
                main_data_next  = push_data;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg)
            begin
                main_valid_next = 1'b1;
                main_data_next  = push_data;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = push_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_item  = main_data_reg;

`ifndef NO_ASSERTIONS
    a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid holds data while output register is empty");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !skid_valid_reg)
        else $error("push into a full buffer");

    a_drain_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !skid_valid_reg && !push) |=> !main_valid_reg)
        else $error("output still valid after last transfer");
`endif

endmodule
`default_nettype wire

// ----- hdl/timed_led_blink_controller.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// timed_led_blink_controller
// Drives one led from millisecond ticks and enable writes.
// ----------------------------------------------------------------------------
// usage
//   in channel: in_valid / in_stall / in_item. command 0 is a one ms tick,
//   command 1 an enable write with request_ms (0 off, -1 blink forever,
//   above 3600000 steady on, other positives a timed blink).
//   out channel: out_valid / out_stall / out_item, one result per input
//   transfer, carrying the led level and the remaining timeout in ms.
//   cfg channel: cfg_valid / cfg_ready / cfg_data writes freq_level
//   (half period 250, 500 or 1000 ms); cfg_ready is always high.
//   each result is registered in the output buffer on its input transfer.
//   throughput: one item per cycle while in_stall is low; the state
//   update is a single compare and count step between the state registers.
//   stall: the output register plus a skid stage absorb one extra result,
//   in_stall rises only when both hold data.
//   reset: led dark, no blink, no timeout, freq_level 1, buffers empty.
// ----------------------------------------------------------------------------
module timed_led_blink_controller
    import tlb_pkg::*;
#(
    parameter int unsigned MAX_BLINK_MS    = MAX_BLINK_MS_DEF,
    parameter int unsigned SETTLE_DELAY_MS = SETTLE_DELAY_MS_DEF
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire tlb_in_item_t  in_item,
    output logic               out_valid,
    input  wire logic          out_stall,
    output tlb_out_item_t      out_item,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [1:0]    cfg_data
);

    logic          accept;
    logic          buf_full;
    tlb_out_item_t result;

    assign in_stall  = buf_full;
    assign accept    = in_valid && !buf_full;
    assign cfg_ready = 1'b1;

    tlb_core #(
        .MAX_BLINK_MS    (MAX_BLINK_MS),
        .SETTLE_DELAY_MS (SETTLE_DELAY_MS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_accept (accept),
        .item        (in_item),
        .cfg_write   (cfg_valid && cfg_ready),
        .cfg_data    (cfg_data),
        .result      (result)
    );

    // result is taken in the same cycle as the input transfer
    tlb_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (result),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule
`default_nettype wire

// ----- tb/timed_led_blink_controller_tb.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// timed_led_blink_controller_tb
// Self-checking bench for the led blink controller. A queue-fed driver offers
// ticks and enable writes, a monitor predicts the led level and the remaining
// timeout for every input transfer and checks each output transfer in order.
// Phases run at several blink rates; channels idle at random in later phases.
// ----------------------------------------------------------------------------
module timed_led_blink_controller_tb;
    import tlb_pkg::*;

    localparam int LED_MAX_BLINK = int'(MAX_BLINK_MS_DEF);
    localparam int LED_SETTLE    = int'(SETTLE_DELAY_MS_DEF);
    localparam int HOLD_CYCLES   = 40;

    logic          clk;
    logic          rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_stall;
    tlb_in_item_t  in_item = '0;
    logic          out_valid;
    logic          out_stall = 1'b0;
    tlb_out_item_t out_item;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [1:0]    cfg_data = '0;

    timed_led_blink_controller dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    tlb_in_item_t  pending_items[$];
    tlb_out_item_t led_results_due[$];

    int unsigned items_pushed = 0;
    int unsigned items_taken  = 0;
    int unsigned freq_writes  = 0;
    int unsigned error_count  = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_trig = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;
    logic        in_fire = 1'b0;

    // predicted block state
    logic [1:0]  m_freq    = FREQ_LEVEL_RESET;
    tlb_mode_t   m_mode    = MODE_IDLE;
    logic [9:0]  m_phase   = '0;
    logic        m_led     = 1'b0;
    logic [13:0] m_timeout = '0;
    logic [5:0]  m_settle  = '0;
    logic        m_target  = 1'b0;

    task automatic report_mismatch(string what);
        if (error_count < 100)
            $display("mismatch: %s", what);
        error_count++;
    endtask

    function automatic void settle_toward(logic lvl);
        m_mode   = MODE_IDLE;
        m_phase  = '0;
        m_target = lvl;
        if (LED_SETTLE == 0)
        begin
            m_settle = '0;
            m_led    = lvl;
        end
        else
        begin
            m_settle = 6'(LED_SETTLE);
        end
    endfunction

    function automatic void light_blink();
        m_mode   = MODE_BLINK;
        m_phase  = '0;
        m_settle = '0;
        m_led    = 1'b1;
    endfunction

    function automatic tlb_out_item_t step_led_model(tlb_in_item_t it);
        tlb_out_item_t      r;
        logic signed [31:0] req;
        int                 half;
        req  = it.request_ms;
        half = (m_freq == FREQ_FAST) ? int'(HALF_FAST_MS) :
               (m_freq == FREQ_SLOW) ? int'(HALF_SLOW_MS) : int'(HALF_MID_MS);
        if (it.command == CMD_WRITE)
        begin
            m_timeout = '0;
            if (req == 0)
                settle_toward(1'b0);
            else if (req == REQ_BLINK_FOREVER)
                light_blink();
            else if (req > STEADY_THRESHOLD)
                settle_toward(1'b1);
            else if (req > 0)
            begin
                light_blink();
                m_timeout = (req > LED_MAX_BLINK) ? 14'(LED_MAX_BLINK) : req[13:0];
            end
        end
        else
        begin
            if (m_mode == MODE_BLINK)
            begin
                if (int'(m_phase) + 1 >= half)
                begin
                    m_led   = ~m_led;
                    m_phase = '0;
                end
                else
                begin
                    m_phase = m_phase + 10'd1;
                end
            end
            else if (m_settle != 0)
            begin
                m_settle = m_settle - 6'd1;
                if (m_settle == 0)
                    m_led = m_target;
            end
            if (m_timeout != 0)
            begin
                m_timeout = m_timeout - 14'd1;
                if (m_timeout == 0)
                    settle_toward(1'b0);
            end
        end
        r.led_level    = m_led;
        r.remaining_ms = m_timeout;
        return r;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // driver: a new item only once the current one has been taken
    always @(negedge clk)
    begin
        if (!in_valid || in_fire)
        begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_item  <= pending_items.pop_front();
                in_valid <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver: random stall, plus a long hold-off when requested
    always @(negedge clk)
    begin
        if (hold_seen != hold_trig)
        begin
            hold_seen <= hold_trig;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // monitor: check output transfers first, they belong to earlier inputs
    always @(posedge clk)
    begin : monitor
        tlb_out_item_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (led_results_due.size() == 0)
                begin
                    report_mismatch($sformatf("result with nothing due: led %0b rem %0d",
                                              out_item.led_level, out_item.remaining_ms));
                end
                else
                begin
                    want = led_results_due.pop_front();
                    if (out_item.led_level !== want.led_level)
                        report_mismatch($sformatf("led_level got %0b want %0b",
                                                  out_item.led_level, want.led_level));
                    if (out_item.remaining_ms !== want.remaining_ms)
                        report_mismatch($sformatf("remaining_ms got %0d want %0d",
                                                  out_item.remaining_ms, want.remaining_ms));
                end
            end
            if (in_valid && !in_stall)
            begin
                led_results_due.push_back(step_led_model(in_item));
                items_taken <= items_taken + 1;
            end
            if (cfg_valid && cfg_ready)
            begin
                m_freq = cfg_data;
                freq_writes <= freq_writes + 1;
            end
        end
        in_fire <= in_valid && !in_stall && rst_n;
    end

    task automatic push_item(logic cmd, logic signed [31:0] req);
        tlb_in_item_t it;
        it.command    = cmd;
        it.request_ms = req;
        pending_items.push_back(it);
        items_pushed++;
    endtask

    function automatic logic signed [31:0] random_request();
        int unsigned        k;
        logic signed [31:0] v;
        k = $urandom_range(99);
        if (k < 14)
            v = 32'sd0;
        else if (k < 28)
            v = REQ_BLINK_FOREVER;
        else if (k < 50)
            v = 32'($urandom_range(40, 1));
        else if (k < 58)
            v = 32'($urandom_range(20000, 41));
        else if (k < 64)
            v = STEADY_THRESHOLD + 32'($urandom_range(1000, 1));
        else if (k < 68)
            v = STEADY_THRESHOLD;
        else if (k < 74)
            v = {1'b0, 31'($urandom)};
        else if (k < 86)
            v = 32'(-int'($urandom_range(1000, 2)));
        else
            v = 32'($urandom);
        return v;
    endfunction

    // mostly a write followed by a run of ticks, some noise items between
    task automatic push_random(int unsigned n);
        int unsigned done;
        int unsigned run;
        done = 0;
        while (done < n)
        begin
            if ($urandom_range(99) < 10)
            begin
                push_item(1'($urandom), 32'($urandom));
                done++;
            end
            else
            begin
                push_item(CMD_WRITE, random_request());
                run = ($urandom_range(9) == 0) ? $urandom_range(280, 240) : $urandom_range(40);
                if (run > n - done - 1)
                    run = n - done - 1;
                repeat (run) push_item(CMD_TICK, 32'($urandom));
                done += run + 1;
            end
        end
    endtask

    task automatic wait_drained();
        do @(negedge clk);
        while (items_taken != items_pushed || led_results_due.size() != 0);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_freq(logic [1:0] lvl);
        int unsigned seen;
        seen = freq_writes;
        cfg_data  <= lvl;
        cfg_valid <= 1'b1;
        do @(negedge clk);
        while (freq_writes == seen);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: request extremes, stop while blinking, timeout expiry
        push_item(CMD_TICK, 32'sd0);
        push_item(CMD_TICK, -32'sd1);
        push_item(CMD_WRITE, 32'sd0);
        push_item(CMD_TICK, 32'sd0);
        push_item(CMD_WRITE, REQ_BLINK_FOREVER);
        push_item(CMD_TICK, 32'sd0);
        push_item(CMD_WRITE, 32'sd1);
        push_item(CMD_TICK, 32'sd0);
        push_item(CMD_TICK, 32'sd0);
        push_item(CMD_WRITE, 32'sd15000);
        push_item(CMD_WRITE, 32'sd15001);
        push_item(CMD_WRITE, STEADY_THRESHOLD);
        push_item(CMD_WRITE, STEADY_THRESHOLD + 32'sd1);
        push_item(CMD_WRITE, 32'sh7fffffff);
        push_item(CMD_WRITE, 32'sh80000000);
        push_item(CMD_WRITE, -32'sd2);
        push_item(CMD_WRITE, REQ_BLINK_FOREVER);
        push_item(CMD_TICK, 32'sd0);
        push_item(CMD_TICK, 32'sd0);
        push_item(CMD_WRITE, 32'sd0);
        push_item(CMD_TICK, 32'sd0);
        push_item(CMD_WRITE, 32'sd20);
        push_item(CMD_WRITE, -32'sd5);
        push_item(CMD_TICK, 32'sd0);

        // no idling, reset blink rate
        push_random(60);
        // leave a long phase count behind so the faster rate toggles at once
        push_item(CMD_WRITE, REQ_BLINK_FOREVER);
        repeat (300) push_item(CMD_TICK, 32'($urandom));
        wait_drained();
        write_freq(FREQ_FAST);

        // sender idles
        send_idle_pct = 58;
        push_item(CMD_TICK, 32'sd0);
        push_random(50);
        wait_drained();
        write_freq(2'd3);

        // receiver stalls, with one long hold-off while items keep coming
        send_idle_pct  = 0;
        recv_stall_pct = 58;
        push_random(35);
        hold_trig = hold_trig + 1;
        wait_drained();
        push_random(35);
        wait_drained();
        write_freq(FREQ_SLOW);

        // both sides idle
        send_idle_pct  = 33;
        recv_stall_pct = 33;
        push_random(45);
        wait_drained();
        repeat (5) @(negedge clk);

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
`default_nettype wire

// ----- files.f -----
hdl/tlb_pkg.sv
hdl/tlb_core.sv
hdl/tlb_out_buf.sv
hdl/timed_led_blink_controller.sv
tb/timed_led_blink_controller_tb.sv
